[rtl/core/tbml_pkg.sv]
// Package: shared types and codes for the tunnel bridge MAC learning block.
`timescale 1ns / 1ps
`default_nettype none
package tbml_pkg;

   localparam int MAC_W = 48;
   localparam int PORT_W = 8;
   localparam int VNI_W = 24;
   localparam int IP_W = 32;
   localparam int CNT_W = 64;
   localparam int STAT_W = 3;
   localparam int HKEY_W = MAC_W + PORT_W;
   localparam int TUN_W = VNI_W + IP_W;
   localparam int GROUP = 32;
   localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_INGRESS = 2'd0,
      ACT_EGRESS  = 2'd1,
      ACT_LOAD_VNI = 2'd2,
      ACT_LOAD_HOST = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_LEARNED = 3'd1,
      ST_FLOODED = 3'd2,
      ST_UNK_VNI = 3'd3,
      ST_NO_ENT  = 3'd4,
      ST_NO_CFG  = 3'd5,
      ST_FULL    = 3'd6,
      ST_LOADED  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_VSRCH,
      FSM_VDONE,
      FSM_HSRCH,
      FSM_HDONE,
      FSM_UPD,
      FSM_OUT
   } fsm_type;

   typedef enum logic [1:0] {
      UPD_RX,
      UPD_TX,
      UPD_FLOOD
   } upd_type;

   localparam logic [1:0] CSR_TUNNEL_PORT = 2'd0;
   localparam logic [1:0] CSR_TUNNEL_PORT_VALID = 2'd1;

endpackage
`default_nettype wire

[rtl/core/tbml_cell.sv]
// One table cell: holds one key, compares it against two queries.
`timescale 1ns / 1ps
`default_nettype none
module tbml_cell #(
   parameter int KEY_W = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [KEY_W-1:0] wr_key,
   input  wire logic [KEY_W-1:0] q0,
   input  wire logic [KEY_W-1:0] q1,
   output logic                  m0,
   output logic                  m1
);
   logic             valid_ff;
   logic [KEY_W-1:0] key_ff;
   logic             m0_ff;
   logic             m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         m0_ff <= 1'b0;
         m1_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff <= 1'b1;
         end
         m0_ff <= valid_ff && (key_ff == q0);
         m1_ff <= valid_ff && (key_ff == q1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_ff <= wr_key;
      end
   end

   assign m0 = m0_ff;
   assign m1 = m1_ff;
endmodule
`default_nettype wire

[rtl/core/tbml_table.sv]
// Associative table: row of cells plus a two-level registered match reduction.
`timescale 1ns / 1ps
`default_nettype none
module tbml_table
   import tbml_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int KEY_W = 24,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [IW-1:0]    wr_idx,
   input  wire logic [KEY_W-1:0] wr_key,
   input  wire logic [KEY_W-1:0] q0,
   input  wire logic [KEY_W-1:0] q1,
   output logic                  hit0,
   output logic [IW-1:0]         idx0,
   output logic                  hit1,
   output logic [IW-1:0]         idx1
);
   localparam int NG = (DEPTH + GROUP - 1) / GROUP;

   logic [DEPTH-1:0] m0;
   logic [DEPTH-1:0] m1;
   logic [NG-1:0]    ghit0_ff, ghit1_ff, ghit0_in, ghit1_in;
   logic [IW-1:0]    gidx0_ff [NG];
   logic [IW-1:0]    gidx1_ff [NG];
   logic [IW-1:0]    gidx0_in [NG];
   logic [IW-1:0]    gidx1_in [NG];
   logic             hit0_ff, hit1_ff, hit0_in, hit1_in;
   logic [IW-1:0]    idx0_ff, idx1_ff, idx0_in, idx1_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tbml_cell #(.KEY_W(KEY_W)) u_cell (
         .clock (clock),
         .reset (reset),
         .wr_en (wr_en && (wr_idx == IW'(i))),
         .wr_key(wr_key),
         .q0    (q0),
         .q1    (q1),
         .m0    (m0[i]),
         .m1    (m1[i])
      );
   end

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         ghit0_in[g] = 1'b0;
         ghit1_in[g] = 1'b0;
         gidx0_in[g] = '0;
         gidx1_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < DEPTH) begin
               ghit0_in[g] = ghit0_in[g] | m0[g * GROUP + k];
               ghit1_in[g] = ghit1_in[g] | m1[g * GROUP + k];
               gidx0_in[g] = gidx0_in[g] | (m0[g * GROUP + k] ? IW'(g * GROUP + k) : '0);
               gidx1_in[g] = gidx1_in[g] | (m1[g * GROUP + k] ? IW'(g * GROUP + k) : '0);
            end
         end
      end
   end

   always_comb begin
      hit0_in = 1'b0;
      hit1_in = 1'b0;
      idx0_in = '0;
      idx1_in = '0;
      for (int g = 0; g < NG; g++) begin
         hit0_in = hit0_in | ghit0_ff[g];
         hit1_in = hit1_in | ghit1_ff[g];
         idx0_in = idx0_in | gidx0_ff[g];
         idx1_in = idx1_in | gidx1_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghit0_ff <= '0;
         ghit1_ff <= '0;
         hit0_ff <= 1'b0;
         hit1_ff <= 1'b0;
      end else begin
         ghit0_ff <= ghit0_in;
         ghit1_ff <= ghit1_in;
         hit0_ff <= hit0_in;
         hit1_ff <= hit1_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NG; g++) begin
         gidx0_ff[g] <= gidx0_in[g];
         gidx1_ff[g] <= gidx1_in[g];
      end
      idx0_ff <= idx0_in;
      idx1_ff <= idx1_in;
   end

   assign hit0 = hit0_ff;
   assign hit1 = hit1_ff;
   assign idx0 = idx0_ff;
   assign idx1 = idx1_ff;
endmodule
`default_nettype wire

[rtl/core/tunnel_bridge_mac_learning_top.sv]
// Top level: tunnel learning bridge with VNI map and host MAC table.
// A table search passes the cell compare, group reduce and final reduce registers;
// ingress searches both tables, the VNI table and then the host table.
// Egress without tunnel port config goes straight to the result with ST_NO_CFG.
// One request at a time: req_tready is high only while the FSM is idle.
// Reset clears both fill counts, all cell valid bits and the config registers.
`timescale 1ns / 1ps
`default_nettype none
module tunnel_bridge_mac_learning_top
   import tbml_pkg::*;
#(
   parameter int VNI_ENTRIES = 1024,
   parameter int HOST_ENTRIES = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mac[47:0], port[55:48], vni[79:56], peer_ip[111:80]
   input  wire logic [111:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // forward[0], out_port[8:1], out_is_ingress[9], out_vni[33:10],
   // out_peer_ip[65:34], packet_count[129:66], zero pad[135:130]
   output logic [135:0]      rsp_tdata,
   // status[2:0]
   output logic [2:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_data
);
   localparam int VIW = (VNI_ENTRIES > 1) ? $clog2(VNI_ENTRIES) : 1;
   localparam int HIW = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
   localparam int VCW = $clog2(VNI_ENTRIES + 1);
   localparam int HCW = $clog2(HOST_ENTRIES + 1);

   fsm_type             state_ff, state_in;
   logic [1:0]          cnt_ff, cnt_in;
   action_type          act_ff;
   logic [MAC_W-1:0]    mac_ff;
   logic [PORT_W-1:0]   port_ff;
   logic [VNI_W-1:0]    tid_ff;
   logic [IP_W-1:0]     ip_ff;
   logic [PORT_W-1:0]   tport_ff;
   logic                tpv_ff;
   logic [VCW-1:0]      vcnt_ff, vcnt_in;
   logic [HCW-1:0]      hcnt_ff, hcnt_in;
   logic                accept;

   logic                res_fwd_ff, res_fwd_in;
   logic [PORT_W-1:0]   res_port_ff, res_port_in;
   logic                res_ing_ff, res_ing_in;
   logic [TUN_W-1:0]    res_tun_ff, res_tun_in;
   logic [CNT_W-1:0]    res_cnt_ff, res_cnt_in;
   status_type          res_stat_ff, res_stat_in;
   upd_type             upd_ff, upd_in;
   logic [HIW-1:0]      upd_idx_ff, upd_idx_in;

   logic                rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [135:0]        rsp_data_ff;
   logic [2:0]          rsp_user_ff;

   logic                vt_we;
   logic [VIW-1:0]      vt_widx;
   logic                vt_hit, vt_hit1;
   logic [VIW-1:0]      vt_idx, vt_idx1;
   logic                ht_we;
   logic [HIW-1:0]      ht_widx;
   logic [HKEY_W-1:0]   ht_q0, ht_q1;
   logic                ht_hit0, ht_hit1;
   logic [HIW-1:0]      ht_idx0, ht_idx1;

   logic [PORT_W-1:0]   vport_mem [VNI_ENTRIES];
   logic [PORT_W-1:0]   vport_rd_ff;
   logic                vm_we, vm_re;
   logic [VIW-1:0]      vm_waddr, vm_raddr;

   logic [TUN_W-1:0]    tun_mem [HOST_ENTRIES];
   logic [CNT_W-1:0]    rx_mem [HOST_ENTRIES];
   logic [CNT_W-1:0]    tx_mem [HOST_ENTRIES];
   logic [TUN_W-1:0]    tun_rd_ff;
   logic [CNT_W-1:0]    rx_rd_ff, tx_rd_ff;
   logic                tun_we, rx_we, tx_we, h_re;
   logic [HIW-1:0]      h_waddr, h_raddr;
   logic [CNT_W-1:0]    rx_wdata, tx_wdata;

   assign req_tready = (state_ff == FSM_IDLE);
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   tbml_table #(.DEPTH(VNI_ENTRIES), .KEY_W(VNI_W)) u_vtab (
      .clock (clock),
      .reset (reset),
      .wr_en (vt_we),
      .wr_idx(vt_widx),
      .wr_key(tid_ff),
      .q0    (tid_ff),
      .q1    (tid_ff),
      .hit0  (vt_hit),
      .idx0  (vt_idx),
      .hit1  (vt_hit1),
      .idx1  (vt_idx1)
   );

   assign ht_q0 = {mac_ff, (act_ff == ACT_INGRESS) ? vport_rd_ff : port_ff};
   assign ht_q1 = {BCAST_MAC, port_ff};

   tbml_table #(.DEPTH(HOST_ENTRIES), .KEY_W(HKEY_W)) u_htab (
      .clock (clock),
      .reset (reset),
      .wr_en (ht_we),
      .wr_idx(ht_widx),
      .wr_key(ht_q0),
      .q0    (ht_q0),
      .q1    (ht_q1),
      .hit0  (ht_hit0),
      .idx0  (ht_idx0),
      .hit1  (ht_hit1),
      .idx1  (ht_idx1)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      vcnt_in = vcnt_ff;
      hcnt_in = hcnt_ff;
      res_fwd_in = res_fwd_ff;
      res_port_in = res_port_ff;
      res_ing_in = res_ing_ff;
      res_tun_in = res_tun_ff;
      res_cnt_in = res_cnt_ff;
      res_stat_in = res_stat_ff;
      upd_in = upd_ff;
      upd_idx_in = upd_idx_ff;
      vt_we = 1'b0;
      vt_widx = vcnt_ff[VIW-1:0];
      ht_we = 1'b0;
      ht_widx = hcnt_ff[HIW-1:0];
      vm_we = 1'b0;
      vm_waddr = vt_idx;
      vm_re = 1'b0;
      vm_raddr = vt_idx;
      tun_we = 1'b0;
      rx_we = 1'b0;
      tx_we = 1'b0;
      h_waddr = hcnt_ff[HIW-1:0];
      rx_wdata = '0;
      tx_wdata = '0;
      h_re = 1'b0;
      h_raddr = ht_idx0;
      rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               res_fwd_in = 1'b0;
               res_port_in = '0;
               res_ing_in = 1'b0;
               res_tun_in = '0;
               res_cnt_in = '0;
               res_stat_in = ST_HIT;
               cnt_in = 2'd2;
               case (action_type'(req_tuser))
                  ACT_INGRESS, ACT_LOAD_VNI: state_in = FSM_VSRCH;
                  ACT_EGRESS: begin
                     if (!tpv_ff) begin
                        res_stat_in = ST_NO_CFG;
                        state_in = FSM_OUT;
                     end else begin
                        state_in = FSM_HSRCH;
                     end
                  end
                  default: state_in = FSM_HSRCH;
               endcase
            end
         end
         FSM_VSRCH: begin
            if (cnt_ff == 2'd0) begin
               state_in = FSM_VDONE;
            end else begin
               cnt_in = cnt_ff - 2'd1;
            end
         end
         FSM_VDONE: begin
            state_in = FSM_OUT;
            if (act_ff == ACT_INGRESS) begin
               if (!vt_hit) begin
                  res_stat_in = ST_UNK_VNI;
               end else begin
                  vm_re = 1'b1;
                  cnt_in = 2'd2;
                  state_in = FSM_HSRCH;
               end
            end else begin
               res_stat_in = ST_LOADED;
               if (vt_hit) begin
                  vm_we = 1'b1;
               end else if (vcnt_ff == VCW'(VNI_ENTRIES)) begin
                  res_stat_in = ST_FULL;
               end else begin
                  vt_we = 1'b1;
                  vm_we = 1'b1;
                  vm_waddr = vcnt_ff[VIW-1:0];
                  vcnt_in = vcnt_ff + VCW'(1);
               end
            end
         end
         FSM_HSRCH: begin
            if (cnt_ff == 2'd0) begin
               state_in = FSM_HDONE;
            end else begin
               cnt_in = cnt_ff - 2'd1;
            end
         end
         FSM_HDONE: begin
            state_in = FSM_OUT;
            case (act_ff)
               ACT_INGRESS: begin
                  if (ht_hit0) begin
                     h_re = 1'b1;
                     upd_idx_in = ht_idx0;
                     upd_in = UPD_RX;
                     res_stat_in = ST_HIT;
                     state_in = FSM_UPD;
                  end else if (hcnt_ff == HCW'(HOST_ENTRIES)) begin
                     res_stat_in = ST_FULL;
                  end else begin
                     ht_we = 1'b1;
                     tun_we = 1'b1;
                     rx_we = 1'b1;
                     tx_we = 1'b1;
                     rx_wdata = CNT_W'(1);
                     hcnt_in = hcnt_ff + HCW'(1);
                     res_fwd_in = 1'b1;
                     res_port_in = vport_rd_ff;
                     res_ing_in = 1'b1;
                     res_cnt_in = CNT_W'(1);
                     res_stat_in = ST_LEARNED;
                  end
               end
               ACT_EGRESS: begin
                  if (ht_hit0) begin
                     h_re = 1'b1;
                     upd_idx_in = ht_idx0;
                     upd_in = UPD_TX;
                     res_stat_in = ST_HIT;
                     state_in = FSM_UPD;
                  end else if (ht_hit1) begin
                     h_re = 1'b1;
                     h_raddr = ht_idx1;
                     upd_idx_in = ht_idx1;
                     upd_in = UPD_FLOOD;
                     res_stat_in = ST_FLOODED;
                     state_in = FSM_UPD;
                  end else begin
                     res_stat_in = ST_NO_ENT;
                  end
               end
               default: begin
                  res_stat_in = ST_LOADED;
                  if (ht_hit0) begin
                     h_waddr = ht_idx0;
                     tun_we = 1'b1;
                     rx_we = 1'b1;
                     tx_we = 1'b1;
                  end else if (hcnt_ff == HCW'(HOST_ENTRIES)) begin
                     res_stat_in = ST_FULL;
                  end else begin
                     ht_we = 1'b1;
                     tun_we = 1'b1;
                     rx_we = 1'b1;
                     tx_we = 1'b1;
                     hcnt_in = hcnt_ff + HCW'(1);
                  end
               end
            endcase
         end
         FSM_UPD: begin
            state_in = FSM_OUT;
            h_waddr = upd_idx_ff;
            res_fwd_in = 1'b1;
            case (upd_ff)
               UPD_RX: begin
                  rx_we = 1'b1;
                  rx_wdata = rx_rd_ff + CNT_W'(1);
                  res_port_in = vport_rd_ff;
                  res_ing_in = 1'b1;
                  res_cnt_in = rx_rd_ff + CNT_W'(1);
               end
               UPD_TX: begin
                  tx_we = 1'b1;
                  tx_wdata = tx_rd_ff + CNT_W'(1);
                  res_port_in = tport_ff;
                  res_tun_in = tun_rd_ff;
                  res_cnt_in = tx_rd_ff + CNT_W'(1);
               end
               default: begin
                  res_port_in = tport_ff;
                  res_tun_in = tun_rd_ff;
               end
            endcase
         end
         FSM_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         cnt_ff <= '0;
         vcnt_ff <= '0;
         hcnt_ff <= '0;
         tport_ff <= '0;
         tpv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         vcnt_ff <= vcnt_in;
         hcnt_ff <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TUNNEL_PORT) begin
               tport_ff <= csr_data;
            end else if (csr_index == CSR_TUNNEL_PORT_VALID) begin
               tpv_ff <= csr_data[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= action_type'(req_tuser);
         mac_ff <= req_tdata[47:0];
         port_ff <= req_tdata[55:48];
         tid_ff <= req_tdata[79:56];
         ip_ff <= req_tdata[111:80];
      end
      res_fwd_ff <= res_fwd_in;
      res_port_ff <= res_port_in;
      res_ing_ff <= res_ing_in;
      res_tun_ff <= res_tun_in;
      res_cnt_ff <= res_cnt_in;
      res_stat_ff <= res_stat_in;
      upd_ff <= upd_in;
      upd_idx_ff <= upd_idx_in;
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, res_cnt_ff, res_tun_ff[IP_W-1:0], res_tun_ff[TUN_W-1:IP_W],
                         res_ing_ff, res_port_ff, res_fwd_ff};
         rsp_user_ff <= res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vm_we) begin
         vport_mem[vm_waddr] <= port_ff;
      end
      if (vm_re) begin
         vport_rd_ff <= vport_mem[vm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tun_we) begin
         tun_mem[h_waddr] <= {tid_ff, ip_ff};
      end
      if (rx_we) begin
         rx_mem[h_waddr] <= rx_wdata;
      end
      if (tx_we) begin
         tx_mem[h_waddr] <= tx_wdata;
      end
      if (h_re) begin
         tun_rd_ff <= tun_mem[h_raddr];
         rx_rd_ff <= rx_mem[h_raddr];
         tx_rd_ff <= tx_mem[h_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
endmodule
`default_nettype wire
